// ----- rtl/core/stftia_pkg.sv -----
package stftia_pkg;

	// Signed range in which every sample position lives.
	localparam int POS_WIDTH = 64;

	localparam int CFG_W   = 25;  // widest register
	localparam int DIV_W   = 32;  // effective hop and chunk fit in 32 bits
	localparam int LOAD_W  = 34;  // signed preload and postload
	localparam int WIDE_W  = 66;  // headroom for a position plus an offset
	localparam int DIGIT_W = 4;   // dividend bits retired per remainder stage
	localparam int DIV_STAGES = 64 / DIGIT_W;

	localparam logic signed [63:0] POS_HI =
		{{(65 - POS_WIDTH){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
	localparam logic signed [63:0] POS_LO = ~POS_HI;

	typedef enum logic [1:0] {
		REG_FRAME_LEN      = 2'd0,
		REG_HOP_SIZE       = 2'd1,
		REG_AVERAGING      = 2'd2,
		REG_INVERSE_ENABLE = 2'd3
	} reg_index_t;

	typedef enum logic {
		OP_REQUIRED = 1'b0,
		OP_AFFECTED = 1'b1
	} op_t;

endpackage

// ----- rtl/core/stft_interval_alignment.sv -----
// Interval alignment for a short-time transform. A query interval of sample
// positions [query_first, query_last) comes in as one word together with an
// operation flag: required (which samples must be read to produce the
// output) or affected (which outputs a change in the query touches). The
// effective chunk and hop are the averaging factor times the configured frame
// length and hop_size; inverse mode holds only when inverse_enable is set and
// the clamped averaging is 1. Offsets are added with saturation to the signed
// position range and the span is then aligned down at its start and up at its
// end to the hop, using floor division. The block keeps no state between
// words: every word gives exactly one result word, in order. It is a fixed
// pipeline of 23 register stages, and one query is taken in every cycle while
// the output side keeps up. Most of the stages belong to the remainder unit,
// which retires four dividend bits per stage of a 64-bit position over
// sixteen stages. A stall at the output holds every stage at once.
// Configuration must be written while the pipeline is empty.
module stft_interval_alignment (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration write port.
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [stftia_pkg::CFG_W-1:0] cfg_wdata,
	// Query side.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // query_first [63:0], query_last [127:64]
	input  logic         s_tuser,  // operation: 0 required, 1 affected
	// Result side.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [255:0] m_tdata   // span_first, span_last, expected_first,
	                               // expected_last, from the lowest bit up
);

	localparam int DW = stftia_pkg::DIV_W;
	localparam int LW = stftia_pkg::LOAD_W;
	localparam int WW = stftia_pkg::WIDE_W;
	localparam int GW = stftia_pkg::DIGIT_W;
	localparam int NS = stftia_pkg::DIV_STAGES;

	// Saturating add of a position and an offset.
	function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
	                                               logic signed [LW-1:0] b);
		logic signed [WW-1:0] s;
		begin
			s = WW'(a) + WW'(b);
			if (s > WW'(stftia_pkg::POS_HI))
				sat_add = stftia_pkg::POS_HI;
			else if (s < WW'(stftia_pkg::POS_LO))
				sat_add = stftia_pkg::POS_LO;
			else
				sat_add = s[63:0];
		end
	endfunction

	// Four steps of restoring remainder: shift in a bit of the digit, subtract if it fits.
	function automatic logic [DW-1:0] rem_digit(logic [DW-1:0] r, logic [GW-1:0] b,
	                                            logic [DW-1:0] d);
		logic [DW:0] t;
		begin
			t = {1'b0, r};
			for (int i = GW - 1; i >= 0; i--) begin
				t = {t[DW-1:0], b[i]};
				if (t >= {1'b0, d})
					t = t - {1'b0, d};
			end
			rem_digit = t[DW-1:0];
		end
	endfunction

	// Configuration registers.
	logic [24:0] window_q, hop_q;
	logic [6:0]  avg_q;
	logic        inv_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= 25'd2048;
			hop_q    <= 25'd2048;
			avg_q    <= 7'd1;
			inv_en_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (stftia_pkg::reg_index_t'(cfg_addr))
				stftia_pkg::REG_FRAME_LEN:      window_q <= cfg_wdata;
				stftia_pkg::REG_HOP_SIZE:       hop_q    <= cfg_wdata;
				stftia_pkg::REG_AVERAGING:      avg_q    <= cfg_wdata[6:0];
				stftia_pkg::REG_INVERSE_ENABLE: inv_en_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves together whenever the output word can leave.
	logic en;
	logic v_s8;
	assign en       = !v_s8 || m_tready;
	assign s_tready = en;

	// Stage 1: take the query, clamp positions, clamp averaging.
	logic                v_s1;
	logic                op_s1, inv_s1;
	logic signed [63:0]  qf_s1, ql_s1;
	logic [6:0]          avg_s1;
	logic [24:0]         win_s1, hsz_s1;
	logic [6:0]          avg_c;

	always_comb begin
		if (avg_q == 7'd0)
			avg_c = 7'd1;
		else if (avg_q > 7'd100)
			avg_c = 7'd100;
		else
			avg_c = avg_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= s_tuser;
			qf_s1  <= sat_add(s_tdata[63:0], '0);
			ql_s1  <= sat_add(s_tdata[127:64], '0);
			avg_s1 <= avg_c;
			win_s1 <= window_q;
			hsz_s1 <= hop_q;
			inv_s1 <= inv_en_q && (avg_c == 7'd1);
		end
	end

	// Stage 2: effective chunk and hop.
	logic                v_s2, op_s2, inv_s2;
	logic signed [63:0]  qf_s2, ql_s2;
	logic [DW-1:0]       chunk_s2, hop_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2    <= op_s1;
			inv_s2   <= inv_s1;
			qf_s2    <= qf_s1;
			ql_s2    <= ql_s1;
			chunk_s2 <= DW'(avg_s1) * DW'(win_s1);
			hop_s2   <= DW'(avg_s1) * DW'(hsz_s1);
		end
	end

	// Stage 3: preload and postload; a zero hop means no alignment, and the
	// hop of one that stands for it also enters the inverse preload.
	logic                   v_s3, op_s3, inv_s3;
	logic signed [63:0]     qf_s3, ql_s3;
	logic [DW-1:0]          hop_s3;
	logic signed [LW-1:0]   pre_s3, post_s3;
	logic signed [LW-1:0]   pre_c, chunk_x;
	logic [DW-1:0]          hop_c;

	always_comb begin
		hop_c   = (hop_s2 == '0) ? DW'(1) : hop_s2;
		chunk_x = LW'({1'b0, chunk_s2});
		if (inv_s2)
			pre_c = chunk_x - LW'({1'b0, hop_c});
		else
			pre_c = chunk_x >>> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3  <= op_s2;
			inv_s3 <= inv_s2;
			qf_s3  <= qf_s2;
			ql_s3  <= ql_s2;
			hop_s3 <= hop_c;
			pre_s3 <= pre_c;
			post_s3 <= inv_s2 ? pre_c + LW'(1) : chunk_x + LW'(1) - pre_c;
		end
	end

	// Stage 4: offset the query ends. The required form is used for required
	// queries and for every query in inverse mode.
	logic                   v_s4, req_s4;
	logic signed [63:0]     af_s4, al_s4;
	logic [DW-1:0]          hop_s4;
	logic signed [LW-1:0]   pre_s4, post_s4;
	logic                   same_c;

	assign same_c = (op_s3 == stftia_pkg::OP_REQUIRED) || inv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s4  <= (op_s3 == stftia_pkg::OP_REQUIRED);
			af_s4   <= sat_add(qf_s3, same_c ? -pre_s3 : -post_s3);
			al_s4   <= sat_add(ql_s3, same_c ? post_s3 : pre_s3);
			hop_s4  <= hop_s3;
			pre_s4  <= pre_s3;
			post_s4 <= post_s3;
		end
	end

	// Remainder unit. Each position is biased by 2^63 to make it unsigned;
	// a third lane works out 2^63 mod hop so the bias can be taken out again.
	logic                   dv_sx   [1:NS];
	logic                   req_sx  [1:NS];
	logic signed [63:0]     af_sx   [1:NS];
	logic signed [63:0]     al_sx   [1:NS];
	logic [DW-1:0]          hop_sx  [1:NS];
	logic signed [LW-1:0]   pre_sx  [1:NS];
	logic signed [LW-1:0]   post_sx [1:NS];
	logic [63:0]            nf_sx   [1:NS];
	logic [63:0]            nl_sx   [1:NS];
	logic [63:0]            nk_sx   [1:NS];
	logic [DW-1:0]          rf_sx   [1:NS];
	logic [DW-1:0]          rl_sx   [1:NS];
	logic [DW-1:0]          rk_sx   [1:NS];

	logic [63:0] bias_f, bias_l;
	assign bias_f = {~af_s4[63], af_s4[62:0]};
	assign bias_l = {~al_s4[63], al_s4[62:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= NS; j++)
				dv_sx[j] <= 1'b0;
		end else if (en) begin
			dv_sx[1] <= v_s4;
			for (int j = 2; j <= NS; j++)
				dv_sx[j] <= dv_sx[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_sx[1]  <= req_s4;
			af_sx[1]   <= af_s4;
			al_sx[1]   <= al_s4;
			hop_sx[1]  <= hop_s4;
			pre_sx[1]  <= pre_s4;
			post_sx[1] <= post_s4;
			nf_sx[1]   <= bias_f << GW;
			nl_sx[1]   <= bias_l << GW;
			nk_sx[1]   <= 64'h8000_0000_0000_0000 << GW;
			rf_sx[1]   <= rem_digit('0, bias_f[63 -: GW], hop_s4);
			rl_sx[1]   <= rem_digit('0, bias_l[63 -: GW], hop_s4);
			rk_sx[1]   <= rem_digit('0, GW'(1 << (GW - 1)), hop_s4);
			for (int j = 2; j <= NS; j++) begin
				req_sx[j]  <= req_sx[j-1];
				af_sx[j]   <= af_sx[j-1];
				al_sx[j]   <= al_sx[j-1];
				hop_sx[j]  <= hop_sx[j-1];
				pre_sx[j]  <= pre_sx[j-1];
				post_sx[j] <= post_sx[j-1];
				nf_sx[j]   <= nf_sx[j-1] << GW;
				nl_sx[j]   <= nl_sx[j-1] << GW;
				nk_sx[j]   <= nk_sx[j-1] << GW;
				rf_sx[j]   <= rem_digit(rf_sx[j-1], nf_sx[j-1][63 -: GW], hop_sx[j-1]);
				rl_sx[j]   <= rem_digit(rl_sx[j-1], nl_sx[j-1][63 -: GW], hop_sx[j-1]);
				rk_sx[j]   <= rem_digit(rk_sx[j-1], nk_sx[j-1][63 -: GW], hop_sx[j-1]);
			end
		end
	end

	// Stage 6: remove the bias to get the floor remainder of each position.
	logic                   v_s6, req_s6;
	logic signed [63:0]     af_s6, al_s6;
	logic [DW-1:0]          hop_s6, rf_s6, rl_s6;
	logic signed [LW-1:0]   pre_s6, post_s6;
	logic [DW:0]            df_c, dl_c;

	always_comb begin
		df_c = {1'b0, rf_sx[NS]} - {1'b0, rk_sx[NS]};
		dl_c = {1'b0, rl_sx[NS]} - {1'b0, rk_sx[NS]};
		if (df_c[DW])
			df_c = df_c + {1'b0, hop_sx[NS]};
		if (dl_c[DW])
			dl_c = dl_c + {1'b0, hop_sx[NS]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= dv_sx[NS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s6  <= req_sx[NS];
			af_s6   <= af_sx[NS];
			al_s6   <= al_sx[NS];
			hop_s6  <= hop_sx[NS];
			pre_s6  <= pre_sx[NS];
			post_s6 <= post_sx[NS];
			rf_s6   <= df_c[DW-1:0];
			rl_s6   <= dl_c[DW-1:0];
		end
	end

	// Stage 7: align the start down and the end up, clamping at the range.
	logic                   v_s7, req_s7;
	logic signed [63:0]     sf_s7, sl_s7;
	logic signed [LW-1:0]   pre_s7, post_s7;
	logic signed [WW-1:0]   dn_c, up_c;
	logic signed [63:0]     sf_c, sl_c;

	always_comb begin
		dn_c = WW'(af_s6) - WW'({1'b0, rf_s6});
		up_c = WW'(al_s6) + WW'({1'b0, hop_s6}) - WW'({1'b0, rl_s6});
		sf_c = (dn_c < WW'(stftia_pkg::POS_LO)) ? stftia_pkg::POS_LO : dn_c[63:0];
		if (rl_s6 == '0)
			sl_c = al_s6;
		else if (up_c > WW'(stftia_pkg::POS_HI))
			sl_c = stftia_pkg::POS_HI;
		else
			sl_c = up_c[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (en)
			v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s7  <= req_s6;
			sf_s7   <= sf_c;
			sl_s7   <= sl_c;
			pre_s7  <= pre_s6;
			post_s7 <= post_s6;
		end
	end

	// Stage 8: expected output interval for required queries; output word.
	logic [255:0] data_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (en)
			v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s8[63:0]    <= sf_s7;
			data_s8[127:64]  <= sl_s7;
			data_s8[191:128] <= req_s7 ? sat_add(sf_s7, pre_s7) : 64'd0;
			data_s8[255:192] <= req_s7 ? sat_add(sl_s7, -post_s7) : 64'd0;
		end
	end

	assign m_tvalid = v_s8;
	assign m_tdata  = data_s8;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

	// One expected result word: the aligned span and the expected output span.
	typedef struct packed {
		logic signed [63:0] expected_last;
		logic signed [63:0] expected_first;
		logic signed [63:0] span_last;
		logic signed [63:0] span_first;
	} span_word_t;

	// Scoreboard: works out the aligned span for every query taken by the block
	// and compares result words against it in order.
	class span_scoreboard;
		logic [24:0] frame_len;
		logic [24:0] hop_size;
		logic [6:0]  averaging;
		logic        inverse_enable;
		span_word_t  pending[$];
		int          errors;
		int          checked;

		function void reset_regs();
			frame_len      = 25'd2048;
			hop_size       = 25'd2048;
			averaging      = 7'd1;
			inverse_enable = 1'b1;
		endfunction

		function void write_reg(stftia_pkg::reg_index_t idx, logic [24:0] val);
			case (idx)
				stftia_pkg::REG_FRAME_LEN:      frame_len = val;
				stftia_pkg::REG_HOP_SIZE:       hop_size = val;
				stftia_pkg::REG_AVERAGING:      averaging = val[6:0];
				stftia_pkg::REG_INVERSE_ENABLE: inverse_enable = val[0];
				default:            ;
			endcase
		endfunction

		// Saturating add; the offset is always small compared with the range.
		function logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
			logic signed [65:0] s;
			s = 66'(a) + 66'(b);
			if (s > 66'(stftia_pkg::POS_HI))
				return stftia_pkg::POS_HI;
			if (s < 66'(stftia_pkg::POS_LO))
				return stftia_pkg::POS_LO;
			return s[63:0];
		endfunction

		function logic signed [63:0] mod_floor(logic signed [63:0] a, logic signed [63:0] d);
			logic signed [63:0] r;
			r = a % d;
			if (r < 0)
				r = r + d;
			return r;
		endfunction

		function logic signed [63:0] round_down(logic signed [63:0] a, logic signed [63:0] d);
			logic signed [65:0] t;
			t = 66'(a) - 66'(mod_floor(a, d));
			if (t < 66'(stftia_pkg::POS_LO))
				return stftia_pkg::POS_LO;
			return t[63:0];
		endfunction

		function logic signed [63:0] round_up(logic signed [63:0] a, logic signed [63:0] d);
			logic signed [63:0] r;
			logic signed [65:0] t;
			r = mod_floor(a, d);
			if (r == 0)
				return a;
			t = 66'(a) + 66'(d - r);
			if (t > 66'(stftia_pkg::POS_HI))
				return stftia_pkg::POS_HI;
			return t[63:0];
		endfunction

		function void note_query(stftia_pkg::op_t op, logic signed [63:0] qf,
		                         logic signed [63:0] ql);
			logic signed [63:0] avg, chunk, hop, pre, post;
			logic inv;
			span_word_t w;
			avg = 64'(averaging);
			if (avg < 1)
				avg = 1;
			if (avg > 100)
				avg = 100;
			chunk = avg * 64'(frame_len);
			hop = avg * 64'(hop_size);
			if (hop < 1)
				hop = 1;
			inv = inverse_enable && (avg == 1);
			if (inv) begin
				pre = chunk - hop;
				post = pre + 1;
			end else begin
				pre = chunk / 2;
				post = chunk + 1 - pre;
			end
			w = '0;
			if (op == stftia_pkg::OP_REQUIRED || inv) begin
				w.span_first = round_down(add_sat(qf, -pre), hop);
				w.span_last = round_up(add_sat(ql, post), hop);
				if (op == stftia_pkg::OP_REQUIRED) begin
					w.expected_first = add_sat(w.span_first, pre);
					w.expected_last = add_sat(w.span_last, -post);
				end
			end else begin
				w.span_first = round_down(add_sat(qf, -post), hop);
				w.span_last = round_up(add_sat(ql, pre), hop);
			end
			pending.push_back(w);
		endfunction

		function void check_result(logic [255:0] data);
			span_word_t got, want;
			got = data;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h", $time, data);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.span_first !== want.span_first) begin
				$display("%0t: span_first expected %0d actual %0d", $time,
					want.span_first, got.span_first);
				errors++;
			end
			if (got.span_last !== want.span_last) begin
				$display("%0t: span_last expected %0d actual %0d", $time,
					want.span_last, got.span_last);
				errors++;
			end
			if (got.expected_first !== want.expected_first) begin
				$display("%0t: expected_first expected %0d actual %0d", $time,
					want.expected_first, got.expected_first);
				errors++;
			end
			if (got.expected_last !== want.expected_last) begin
				$display("%0t: expected_last expected %0d actual %0d", $time,
					want.expected_last, got.expected_last);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_addr;
	logic [24:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;   // query_first [63:0], query_last [127:64]
	logic         s_tuser;   // operation: 0 required, 1 affected
	logic         m_tvalid;
	logic         m_tready;
	logic [255:0] m_tdata;   // span_first, span_last, expected_first, expected_last

	span_scoreboard sb;

	// Idle rates in percent for each side, changed between phases.
	int  send_idle_pct;
	int  recv_idle_pct;
	// Set while the receiver is told to hold off for a long stretch.
	bit  hold_off;
	int  sent_words;

	stft_interval_alignment dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Safety net: the slowest correct run is far shorter than this.
	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

	// The receiver samples results at the rising edge and changes tready at the
	// falling edge, idling at the rate of the current phase or during a hold-off.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (hold_off)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Writes one register; the write enable drops after each write.
	task automatic write_reg(stftia_pkg::reg_index_t idx, logic [24:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	// Sends one query word; the word is noted when the handshake happens. The
	// valid stays high after the handshake so that words can follow back to
	// back; it drops while the sender idles and when the stream is drained.
	task automatic send_query(stftia_pkg::op_t op, logic signed [63:0] qf,
	                          logic signed [63:0] ql);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {ql, qf};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_query(op, qf, ql);
		sent_words++;
		@(negedge clk);
	endtask

	// Waits until every expected word has come back, then lets the pipeline
	// drain for longer than its 23-stage latency.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic logic signed [63:0] rand_pos();
		logic signed [63:0] v;
		case ($urandom_range(5))
			0: v = {$urandom, $urandom};
			1: v = stftia_pkg::POS_HI - 64'($urandom_range(1 << 26));
			2: v = stftia_pkg::POS_LO + 64'($urandom_range(1 << 26));
			default: v = $signed(64'($urandom_range(1 << 30))) - 64'sd536870912;
		endcase
		return v;
	endfunction

	task automatic random_queries(int n);
		logic signed [63:0] a, b;
		for (int i = 0; i < n; i++) begin
			a = rand_pos();
			b = ($urandom_range(3) == 0) ? rand_pos() : a + 64'($urandom_range(100000));
			send_query(stftia_pkg::op_t'($urandom_range(1)), a, b);
		end
	endtask

	// Picks a random register setting; frame length is a multiple of hop, mostly
	// small.
	task automatic random_setting();
		logic [24:0] hop, mult;
		hop = ($urandom_range(9) == 0) ? 25'($urandom_range(1, 1 << 24))
			: 25'($urandom_range(1, 4096));
		mult = 25'($urandom_range(1, 8));
		if (32'(hop) * 32'(mult) > 32'h0100_0000)
			mult = 1;
		write_reg(stftia_pkg::REG_HOP_SIZE, hop);
		write_reg(stftia_pkg::REG_FRAME_LEN, hop * mult);
		write_reg(stftia_pkg::REG_AVERAGING,
			($urandom_range(1)) ? 25'd1 : 25'($urandom_range(1, 100)));
		write_reg(stftia_pkg::REG_INVERSE_ENABLE, 25'($urandom_range(1)));
	endtask

	initial begin
		logic signed [63:0] edges[6];
		sb = new();
		sb.reset_regs();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		sent_words = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at reset values: extremes of both positions, both
		// operations, saturation at either end of the range.
		edges = '{stftia_pkg::POS_LO, stftia_pkg::POS_LO + 1, -64'sd1, 64'sd0,
			stftia_pkg::POS_HI - 1, stftia_pkg::POS_HI};
		for (int i = 0; i < 6; i++)
			send_query(stftia_pkg::op_t'(i[0]), edges[i], edges[5 - i]);
		send_query(stftia_pkg::OP_REQUIRED, 64'sd100, 64'sd5000);
		send_query(stftia_pkg::OP_AFFECTED, -64'sd3000, 64'sd4097);
		drain();

		// Hop above chunk makes the inverse preload negative; averaging of zero
		// and above 100 are clamped; the largest sizes stress the divider.
		write_reg(stftia_pkg::REG_FRAME_LEN, 25'd1000);
		write_reg(stftia_pkg::REG_HOP_SIZE, 25'd3000);
		send_query(stftia_pkg::OP_REQUIRED, stftia_pkg::POS_LO, stftia_pkg::POS_HI);
		send_query(stftia_pkg::OP_AFFECTED, -64'sd7, 64'sd7);
		drain();
		write_reg(stftia_pkg::REG_AVERAGING, 25'd0);
		write_reg(stftia_pkg::REG_INVERSE_ENABLE, 25'd0);
		send_query(stftia_pkg::OP_AFFECTED, -64'sd12345, 64'sd999);
		drain();
		write_reg(stftia_pkg::REG_AVERAGING, 25'd127);
		write_reg(stftia_pkg::REG_FRAME_LEN, 25'h1FF_FFFF);
		write_reg(stftia_pkg::REG_HOP_SIZE, 25'h100_0000);
		send_query(stftia_pkg::OP_REQUIRED, stftia_pkg::POS_LO + 5, stftia_pkg::POS_HI - 5);
		send_query(stftia_pkg::OP_AFFECTED, 64'sd1, -64'sd1);
		drain();
		write_reg(stftia_pkg::REG_HOP_SIZE, 25'd0);
		write_reg(stftia_pkg::REG_FRAME_LEN, 25'd1);
		write_reg(stftia_pkg::REG_AVERAGING, 25'd1);
		write_reg(stftia_pkg::REG_INVERSE_ENABLE, 25'd1);
		send_query(stftia_pkg::OP_REQUIRED, -64'sd5, 64'sd5);
		send_query(stftia_pkg::OP_AFFECTED, stftia_pkg::POS_HI, stftia_pkg::POS_LO);
		drain();

		// Random part in three idling phases, several settings in each.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 84 : 0;
			recv_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 32 : 0;
			for (int s = 0; s < 4; s++) begin
				random_setting();
				random_queries(48);
				drain();
			end
		end

		// Long hold-off at the output while queries keep coming, so the pipeline
		// fills and the input stalls.
		fork
			begin
				hold_off = 1'b1;
				repeat (200) @(negedge clk);
				hold_off = 1'b0;
			end
			random_queries(60);
		join
		drain();

		$display("Ran %0d queries, %0d results checked, over many register settings",
			sent_words, sb.checked);
		$display("including saturation, clamped averaging, zero hop and output back-pressure.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
